### hdl/lbe_pkg.sv
// Shared constants, coefficient tables and rounding helper of the Legendre basis evaluator.
`default_nettype none

package lbe_pkg;

   localparam int INDEX_W           = 5;
   localparam int X_W               = 32;
   localparam int VALUE_W           = 39;
   localparam int MODE_W            = 2;
   localparam int OPND_W            = 33;
   localparam int PROD_W            = 2 * OPND_W;
   localparam int COEF_W            = 32;
   localparam int CSR_INDEX_W       = 2;
   localparam int CSR_DATA_W        = 5;
   localparam int TERM_LAST         = 31;
   localparam int TABLE_DEPTH       = TERM_LAST + 1;
   localparam int MAX_ORDER_DEFAULT = 31;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ORDER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NORM_MODE = 2'd1;

   localparam logic [MODE_W-1:0] NORM_STANDARD = 2'd0;
   localparam logic [MODE_W-1:0] NORM_ORTHO    = 2'd1;
   localparam logic [MODE_W-1:0] NORM_SQRT_MU  = 2'd2;

   localparam logic signed [X_W-1:0]    X_POS_MAX = 32'sd1073741824;
   localparam logic signed [X_W-1:0]    X_POS_MIN = -32'sd1073741824;
   localparam logic signed [OPND_W-1:0] ONE_Q30   = 33'sd1073741824;
   localparam logic signed [PROD_W-1:0] P_MAX     = 66'sd2147483648;
   localparam logic signed [PROD_W-1:0] P_MIN     = -66'sd2147483648;
   localparam logic signed [PROD_W-1:0] OUT_MAX   = 66'sd274877906943;
   localparam logic signed [PROD_W-1:0] OUT_MIN   = -66'sd274877906944;

   localparam int TABLE_A    = 0;
   localparam int TABLE_B    = 1;
   localparam int TABLE_SQRT = 2;

   typedef logic [COEF_W-1:0] coef_table_type [TABLE_DEPTH];

   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] num);
      logic [63:0] n;
      logic [63:0] r;
      logic [63:0] b;
      n = num;
      r = '0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic coef_table_type build_table(input int sel);
      coef_table_type tbl;
      logic [63:0]    kk;
      logic [63:0]    tmp;
      for (int k = 0; k < TABLE_DEPTH; k++) begin
         kk = 64'(k);
         if (sel == TABLE_SQRT) begin
            tmp = isqrt64(((kk << 1) + 64'd1) << 55);
         end else if (k < 2) begin
            tmp = '0;
         end else if (sel == TABLE_A) begin
            tmp = udiv64((((kk << 1) - 64'd1) << 31) + kk, kk << 1);
         end else begin
            tmp = udiv64(((kk - 64'd1) << 31) + kk, kk << 1);
         end
         tbl[k] = tmp[COEF_W-1:0];
      end
      return tbl;
   endfunction

   localparam coef_table_type A_TABLE    = build_table(TABLE_A);
   localparam coef_table_type B_TABLE    = build_table(TABLE_B);
   localparam coef_table_type SQRT_TABLE = build_table(TABLE_SQRT);

   // Arithmetic right shift that rounds half away from zero.
   function automatic logic signed [PROD_W-1:0] round_shift(input logic signed [PROD_W-1:0] v,
                                                            input int s);
      logic signed [PROD_W-1:0] half;
      logic signed [PROD_W-1:0] sum;
      half = $signed(66'd1) <<< (s - 1);
      sum  = v + half - $signed({{(PROD_W-1){1'b0}}, v[PROD_W-1]});
      return sum >>> s;
   endfunction

   typedef struct packed {
      logic enable;
   } mul_ctrl_type;

endpackage

`default_nettype wire

### hdl/lbe_if.sv
// Channel interfaces of the Legendre basis evaluator: location words, result words, register writes.
`default_nettype none

interface lbe_req_if;
   logic                              valid;
   logic                              ready;
   logic signed [lbe_pkg::X_W-1:0]    x_pos;

   modport source (output valid, output x_pos, input ready);
   modport sink (input valid, input x_pos, output ready);
endinterface

interface lbe_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [lbe_pkg::INDEX_W-1:0]        term_index;
   logic signed [lbe_pkg::VALUE_W-1:0] term_value;
   logic                               last_term;

   modport source (output valid, output term_index, output term_value, output last_term,
                   input ready);
   modport sink (input valid, input term_index, input term_value, input last_term,
                 output ready);
endinterface

interface lbe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [lbe_pkg::CSR_INDEX_W-1:0]   index;
   logic [lbe_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/lbe_mul.sv
// Shared signed multiplier with a registered product.
`default_nettype none

module lbe_mul (
   input  wire logic                                clock,
   input  wire lbe_pkg::mul_ctrl_type               ctrl,
   input  wire logic signed [lbe_pkg::OPND_W-1:0]   op_a,
   input  wire logic signed [lbe_pkg::OPND_W-1:0]   op_b,
   output logic signed [lbe_pkg::PROD_W-1:0]        product_ff
);
   import lbe_pkg::*;

   logic signed [PROD_W-1:0] product_in;

   assign product_in = op_a * op_b;

   always_ff @(posedge clock) begin
      if (ctrl.enable) begin
         product_ff <= product_in;
      end
   end

endmodule

`default_nettype wire

### hdl/legendre_basis_evaluator_core.sv
// Top level of the Legendre basis evaluator: sequencer, recurrence registers and output word.
//
//   channel   direction   word contents
//   req_ch    in          x_pos (signed Q1.30 location)
//   rsp_ch    out         term_index, term_value (signed Q8.30), last_term
//   csr_ch    in          index, data (0 max_order, 1 norm_mode)
//
// Orders 0 and 1 use only the normalise multiply and emit steps; every higher order first runs
// x multiply, round, A multiply, B multiply, subtract and round, all on the one shared multiplier.
// The block takes a new location only when the previous one has sent its last word.
// A stalled result word holds the sequencer in its emit step; register writes are always taken.
// Reset is synchronous and returns both registers to zero and the sequencer to idle.
`default_nettype none

module legendre_basis_evaluator_core #(
   parameter int MAX_ORDER = lbe_pkg::MAX_ORDER_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lbe_req_if.sink    req_ch,
   lbe_rsp_if.source  rsp_ch,
   lbe_csr_if.sink    csr_ch
);
   import lbe_pkg::*;

   localparam int ORDER_CAP = (MAX_ORDER > TERM_LAST) ? TERM_LAST : MAX_ORDER;
   localparam logic [INDEX_W-1:0] ORDER_CAP_W = INDEX_W'(ORDER_CAP);

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] ST_IDLE  = 4'd0;
   localparam logic [STATE_W-1:0] ST_MUL_X = 4'd1;
   localparam logic [STATE_W-1:0] ST_RND_T = 4'd2;
   localparam logic [STATE_W-1:0] ST_MUL_A = 4'd3;
   localparam logic [STATE_W-1:0] ST_MUL_B = 4'd4;
   localparam logic [STATE_W-1:0] ST_SUB   = 4'd5;
   localparam logic [STATE_W-1:0] ST_RND_P = 4'd6;
   localparam logic [STATE_W-1:0] ST_MUL_N = 4'd7;
   localparam logic [STATE_W-1:0] ST_EMIT  = 4'd8;

   logic [STATE_W-1:0]       state_ff, state_in;
   logic [INDEX_W-1:0]       k_ff, k_in;
   logic [INDEX_W-1:0]       last_ff, last_in;
   logic [INDEX_W-1:0]       max_order_ff, max_order_in;
   logic [MODE_W-1:0]        norm_mode_ff, norm_mode_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [OPND_W-1:0] p_ff, p_in;
   logic signed [OPND_W-1:0] prev1_ff, prev1_in;
   logic signed [OPND_W-1:0] prev2_ff, prev2_in;
   logic signed [OPND_W-1:0] t_ff, t_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]       rsp_index_ff, rsp_index_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                     rsp_last_ff, rsp_last_in;

   mul_ctrl_type             mul_ctrl;
   logic signed [OPND_W-1:0] op_a;
   logic signed [OPND_W-1:0] op_b;
   logic signed [PROD_W-1:0] product_ff;

   logic signed [X_W-1:0]    x_clamped;
   logic [INDEX_W-1:0]       last_order;
   logic signed [PROD_W-1:0] t_round;
   logic signed [PROD_W-1:0] p_round;
   logic signed [OPND_W-1:0] p_clamped;
   logic signed [PROD_W-1:0] norm_value;
   logic signed [VALUE_W-1:0] norm_sat;
   logic                     out_free;

   lbe_mul u_mul (
      .clock      (clock),
      .ctrl       (mul_ctrl),
      .op_a       (op_a),
      .op_b       (op_b),
      .product_ff (product_ff)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.term_index = rsp_index_ff;
   assign rsp_ch.term_value = rsp_value_ff;
   assign rsp_ch.last_term  = rsp_last_ff;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      if (req_ch.x_pos > X_POS_MAX) begin
         x_clamped = X_POS_MAX;
      end else if (req_ch.x_pos < X_POS_MIN) begin
         x_clamped = X_POS_MIN;
      end else begin
         x_clamped = req_ch.x_pos;
      end
      last_order = (max_order_ff > ORDER_CAP_W) ? ORDER_CAP_W : max_order_ff;
   end

   always_comb begin
      t_round = round_shift(product_ff, 30);
      p_round = round_shift(acc_ff, 30);
      if (p_round > P_MAX) begin
         p_clamped = P_MAX[OPND_W-1:0];
      end else if (p_round < P_MIN) begin
         p_clamped = P_MIN[OPND_W-1:0];
      end else begin
         p_clamped = p_round[OPND_W-1:0];
      end
      case (norm_mode_ff)
         NORM_ORTHO:   norm_value = round_shift(product_ff, 1);
         NORM_SQRT_MU: norm_value = round_shift(product_ff, 28);
         default:      norm_value = PROD_W'(p_ff);
      endcase
      if (norm_value > OUT_MAX) begin
         norm_sat = OUT_MAX[VALUE_W-1:0];
      end else if (norm_value < OUT_MIN) begin
         norm_sat = OUT_MIN[VALUE_W-1:0];
      end else begin
         norm_sat = norm_value[VALUE_W-1:0];
      end
   end

   always_comb begin
      mul_ctrl.enable = 1'b0;
      op_a            = '0;
      op_b            = '0;
      unique case (state_ff)
         ST_MUL_X: begin
            mul_ctrl.enable = 1'b1;
            op_a            = OPND_W'(x_ff);
            op_b            = prev1_ff;
         end
         ST_MUL_A: begin
            mul_ctrl.enable = 1'b1;
            op_a            = $signed({1'b0, A_TABLE[k_ff]});
            op_b            = t_ff;
         end
         ST_MUL_B: begin
            mul_ctrl.enable = 1'b1;
            op_a            = $signed({1'b0, B_TABLE[k_ff]});
            op_b            = prev2_ff;
         end
         ST_MUL_N: begin
            mul_ctrl.enable = 1'b1;
            op_b            = p_ff;
            if (norm_mode_ff == NORM_SQRT_MU) begin
               op_a = $signed({1'b0, SQRT_TABLE[k_ff]});
            end else begin
               op_a = $signed({{(OPND_W-INDEX_W-1){1'b0}}, k_ff, 1'b1});
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      last_in      = last_ff;
      max_order_in = max_order_ff;
      norm_mode_in = norm_mode_ff;
      x_in         = x_ff;
      p_in         = p_ff;
      prev1_in     = prev1_ff;
      prev2_in     = prev2_ff;
      t_in         = t_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_index_in = rsp_index_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_MAX_ORDER: max_order_in = csr_ch.data[INDEX_W-1:0];
            CSR_NORM_MODE: norm_mode_in = csr_ch.data[MODE_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               x_in     = x_clamped;
               p_in     = ONE_Q30;
               prev1_in = '0;
               prev2_in = '0;
               k_in     = '0;
               last_in  = last_order;
               state_in = ST_MUL_N;
            end
         end
         ST_MUL_X: state_in = ST_RND_T;
         ST_RND_T: begin
            t_in     = t_round[OPND_W-1:0];
            state_in = ST_MUL_A;
         end
         ST_MUL_A: state_in = ST_MUL_B;
         ST_MUL_B: begin
            acc_in   = product_ff;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            acc_in   = acc_ff - product_ff;
            state_in = ST_RND_P;
         end
         ST_RND_P: begin
            p_in     = p_clamped;
            state_in = ST_MUL_N;
         end
         ST_MUL_N: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = k_ff;
               rsp_value_in = norm_sat;
               rsp_last_in  = (k_ff == last_ff);
               prev2_in     = prev1_ff;
               prev1_in     = p_ff;
               if (k_ff == last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in = k_ff + INDEX_W'(1);
                  if (k_ff == '0) begin
                     p_in     = OPND_W'(x_ff);
                     state_in = ST_MUL_N;
                  end else begin
                     state_in = ST_MUL_X;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         max_order_ff <= '0;
         norm_mode_ff <= NORM_STANDARD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_order_ff <= max_order_in;
         norm_mode_ff <= norm_mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff         <= k_in;
      last_ff      <= last_in;
      x_ff         <= x_in;
      p_ff         <= p_in;
      prev1_ff     <= prev1_in;
      prev2_ff     <= prev2_in;
      t_ff         <= t_in;
      acc_ff       <= acc_in;
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

`default_nettype wire

### tb/tb_legendre_basis_evaluator_core.sv
// Self-checking testbench of the Legendre basis evaluator core with a term predictor.
`default_nettype none

module tb_legendre_basis_evaluator_core;
   import lbe_pkg::*;

   localparam longint UNIT_Q30    = 64'sd1073741824;
   localparam longint P_CEIL      = 64'sd2147483648;
   localparam longint TERM_CEIL   = 64'sd274877906943;
   localparam longint TERM_FLOOR  = -64'sd274877906944;
   localparam int     STALL_LIMIT = 2000;
   localparam int     TAIL_CYCLES = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [MODE_W-1:0]      NORM_UNUSED = 2'd3;

   localparam logic signed [X_W-1:0] CORNER_LOCS [13] = '{
      32'sd1073741824, -32'sd1073741824, 32'sd0, 32'sd1, -32'sd1,
      32'sd1073741823, -32'sd1073741823, 32'sh7FFFFFFF, 32'sh80000000,
      32'sd1073741825, -32'sd1073741825, 32'sd536870912, -32'sd357913941
   };

   typedef struct {
      logic [INDEX_W-1:0]        index;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } legendre_term_type;

   class legendre_term_predictor;
      int unsigned       order_sel;
      logic [MODE_W-1:0] norm_sel;
      longint            coef_a [TABLE_DEPTH];
      longint            coef_b [TABLE_DEPTH];
      longint            root_scale [TABLE_DEPTH];
      legendre_term_type pending_terms [$];
      int                mismatches;
      int                terms_checked;
      int                locations;
      int                clamped;

      function new();
         longint kk;
         longint n;
         longint c;
         order_sel     = 0;
         norm_sel      = NORM_STANDARD;
         mismatches    = 0;
         terms_checked = 0;
         locations     = 0;
         clamped       = 0;
         for (int k = 0; k < TABLE_DEPTH; k++) begin
            kk = longint'(k);
            coef_a[k] = (k < 2) ? 0 : (((2 * kk - 1) << 31) + kk) / (2 * kk);
            coef_b[k] = (k < 2) ? 0 : (((kk - 1) << 31) + kk) / (2 * kk);
            n = (2 * kk + 1) << 55;
            root_scale[k] = 0;
            for (int b = 30; b >= 0; b--) begin
               c = root_scale[k] | (64'sd1 << b);
               if (c * c <= n) root_scale[k] = c;
            end
         end
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_MAX_ORDER: order_sel = 32'(data);
            CSR_NORM_MODE: norm_sel = data[MODE_W-1:0];
            default: ;
         endcase
      endfunction

      function longint round_away(longint v, int s);
         longint half;
         half = 64'sd1 << (s - 1);
         if (v >= 0) return (v + half) >>> s;
         return -((-v + half) >>> s);
      endfunction

      function longint limit(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void predict_location(logic signed [X_W-1:0] x_word);
         longint            x;
         longint            p;
         longint            t;
         longint            v;
         longint            prev1;
         longint            prev2;
         int unsigned       last_k;
         legendre_term_type term;
         x = longint'(x_word);
         locations++;
         if (x > UNIT_Q30 || x < -UNIT_Q30) clamped++;
         x = limit(x, -UNIT_Q30, UNIT_Q30);
         last_k = (order_sel > MAX_ORDER_DEFAULT) ? MAX_ORDER_DEFAULT : order_sel;
         prev1 = 0;
         prev2 = 0;
         for (int k = 0; k <= last_k; k++) begin
            if (k == 0) begin
               p = UNIT_Q30;
            end else if (k == 1) begin
               p = x;
            end else begin
               t = round_away(x * prev1, 30);
               p = round_away(coef_a[k] * t - coef_b[k] * prev2, 30);
            end
            p = limit(p, -P_CEIL, P_CEIL);
            prev2 = prev1;
            prev1 = p;
            case (norm_sel)
               NORM_ORTHO:   v = round_away(p * longint'(2 * k + 1), 1);
               NORM_SQRT_MU: v = round_away(p * root_scale[k], 28);
               default:      v = p;
            endcase
            v = limit(v, TERM_FLOOR, TERM_CEIL);
            term.index = INDEX_W'(k);
            term.value = v[VALUE_W-1:0];
            term.last  = (k == last_k);
            pending_terms.push_back(term);
         end
      endfunction

      function void check_term(logic [INDEX_W-1:0] idx, logic signed [VALUE_W-1:0] value,
                               logic last);
         legendre_term_type want;
         if (pending_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected term word: index %0d value %0d last %0b", idx, value, last);
            return;
         end
         want = pending_terms.pop_front();
         terms_checked++;
         if (idx !== want.index || value !== want.value || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("term mismatch: expected index %0d value %0d last %0b, %s%0d %s%0d %s%0b",
                        want.index, want.value, want.last, "got index ", idx, "value ", value,
                        "last ", last);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;
   int   ready_hold = 0;
   int   idle_cycles = 0;
   int   settings_used = 0;

   legendre_term_predictor term_predictor = new();

   lbe_req_if req_bus ();
   lbe_rsp_if rsp_bus ();
   lbe_csr_if csr_bus ();

   legendre_basis_evaluator_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (steady) begin
         rsp_bus.ready <= 1'b1;
      end else if (ready_hold > 0) begin
         ready_hold--;
      end else if (!rsp_bus.ready) begin
         rsp_bus.ready <= 1'b1;
         ready_hold = $urandom_range(0, 12);
      end else if ($urandom_range(0, 2) == 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold = $urandom_range(0, 6);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         term_predictor.check_term(rsp_bus.term_index, rsp_bus.term_value, rsp_bus.last_term);
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic send_location(logic signed [X_W-1:0] x);
      req_bus.valid <= 1'b1;
      req_bus.x_pos <= x;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      term_predictor.predict_location(x);
   endtask

   task automatic maybe_idle();
      if (!steady && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (term_predictor.pending_terms.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      term_predictor.write_reg(idx, data);
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] order, logic [CSR_DATA_W-1:0] norm_data,
                            bit add_spare);
      csr_write(CSR_MAX_ORDER, order);
      csr_write(CSR_NORM_MODE, norm_data);
      if (add_spare)
         csr_write($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B,
                   CSR_DATA_W'($urandom_range(0, 31)));
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic signed [X_W-1:0] random_location();
      longint v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = longint'($urandom_range(0, 32'h8000_0000)) - UNIT_Q30;
         4, 5:       v = longint'($urandom);
         6, 7: begin
            v = UNIT_Q30 - $urandom_range(0, 64);
            if ($urandom_range(0, 1)) v = -v;
         end
         8: begin
            case ($urandom_range(0, 2))
               0:       v = UNIT_Q30;
               1:       v = -UNIT_Q30;
               default: v = 0;
            endcase
         end
         default:    v = longint'($urandom_range(0, 2047)) - 1024;
      endcase
      return v[X_W-1:0];
   endfunction

   initial begin
      logic [CSR_DATA_W-1:0] order_pick;
      req_bus.valid <= 1'b0;
      req_bus.x_pos <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_MAX_ORDER;
      csr_bus.data  <= '0;
      reset         <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_location(32'sd0);
      drain_results();
      configure(5'd31, {3'b000, NORM_STANDARD}, 1'b0);
      foreach (CORNER_LOCS[i]) begin
         maybe_idle();
         send_location(CORNER_LOCS[i]);
      end
      drain_results();
      configure(5'd31, {3'b000, NORM_ORTHO}, 1'b0);
      send_location(32'sd1073741824);
      send_location(-32'sd1073741824);
      send_location(32'sd715827883);
      drain_results();
      configure(5'd31, {3'b000, NORM_SQRT_MU}, 1'b0);
      send_location(32'sd1073741824);
      send_location(-32'sd1073741824);
      send_location(32'sd0);
      drain_results();
      configure(5'd1, {3'b111, NORM_UNUSED}, 1'b0);
      send_location(32'sd1073741824);
      send_location(-32'sd357913941);
      drain_results();
      csr_write(CSR_SPARE_B, 5'b10101);
      csr_write(CSR_SPARE_A, 5'b01010);
      configure(5'd2, {3'b000, NORM_ORTHO}, 1'b0);
      send_location(-32'sd1073741824);

      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 9) steady = 1'b1;
         drain_results();
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: order_pick = 5'd31;
            5, 6, 7:       order_pick = 5'd0;
            8, 9:          order_pick = 5'd1;
            default:       order_pick = CSR_DATA_W'($urandom_range(0, 31));
         endcase
         configure(order_pick, CSR_DATA_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
         for (int i = 0; i < 16; i++) begin
            maybe_idle();
            send_location(random_location());
         end
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d locations (%0d outside [-1,1]) under %0d register settings,",
               term_predictor.locations, term_predictor.clamped, settings_used);
      $display("with %0d term words checked and %0d mismatches",
               term_predictor.terms_checked, term_predictor.mismatches);
      if (term_predictor.mismatches == 0 && term_predictor.pending_terms.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

### files.f
hdl/lbe_pkg.sv
hdl/lbe_if.sv
hdl/lbe_mul.sv
hdl/legendre_basis_evaluator_core.sv
tb/tb_legendre_basis_evaluator_core.sv
